FILE: sv/ppmj_pkg.sv
// ----------------------------------------------------------------------------
// ppmj_pkg
// Types, constants and arithmetic helpers for the projective point map.
// ----------------------------------------------------------------------------
package ppmj_pkg;

  localparam int VW = 32;             // value width
  localparam int FB = 16;             // fraction bits
  localparam int MW = 2 * VW;         // full product width
  localparam int NW = MW - FB + 1;    // w, u, v and numerator width
  localparam int DIV_STEPS = 2;       // quotient bits per divider stage
  localparam int DS = VW / DIV_STEPS; // divider stages

  localparam int CW = 64;             // config data width
  localparam int CIW = 3;             // config index width

  localparam logic [CIW-1:0] CFG_M00_M01 = 3'd0;
  localparam logic [CIW-1:0] CFG_M02_M10 = 3'd1;
  localparam logic [CIW-1:0] CFG_M11_M12 = 3'd2;
  localparam logic [CIW-1:0] CFG_M20_M21 = 3'd3;
  localparam logic [CIW-1:0] CFG_M22     = 3'd4;

  localparam logic [1:0] ST_VALID   = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_INF     = 2'd2;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [VW-1:0] lq;   // low dividend bits shift out, quotient bits shift in
    logic          big;  // quotient needs more than VW bits
    logic          neg;
  } lane_t;

  typedef struct packed {
    logic [VW-1:0]         x;
    logic [VW-1:0]         y;
    logic [VW-1:0]         j00;
    logic [VW-1:0]         j01;
    logic [VW-1:0]         j10;
    logic [VW-1:0]         j11;
    logic                  inv;
    logic                  upd;
    logic [7:0][MW-1:0]    p;
    logic [NW-1:0]         w;
    logic [NW-1:0]         u;
    logic [NW-1:0]         v;
    lane_t [3:0]           ln;
    logic [VW-1:0]         qx;
    logic [VW-1:0]         qy;
    logic [3:0][VW-1:0]    k;
    logic                  ovq;
    logic                  ovk;
  } item_t;

  typedef struct packed {
    logic [VW-1:0]      mx;
    logic [VW-1:0]      my;
    logic [1:0]         status;
    logic               ov;
    logic [3:0][VW-1:0] jac;
  } out_t;

  function automatic logic [MW-1:0] smul(input logic signed [VW-1:0] a,
                                         input logic signed [VW-1:0] b);
    logic signed [MW-1:0] ea;
    logic signed [MW-1:0] eb;
    ea = a;
    eb = b;
    smul = ea * eb;
  endfunction

  // floor(product / 2^FB), sign extended to NW
  function automatic logic [NW-1:0] pfl(input logic [MW-1:0] p);
    pfl = {p[MW-1], p[MW-1:FB]};
  endfunction

  function automatic logic [NW-1:0] sxn(input logic [VW-1:0] a);
    sxn = {{(NW-VW){a[VW-1]}}, a};
  endfunction

  function automatic logic [NW:0] sadd(input logic [NW-1:0] a, input logic [NW-1:0] b);
    sadd = {a[NW-1], a} + {b[NW-1], b};
  endfunction

  // {ov, value} saturated to VW bits
  function automatic logic [VW:0] sat(input logic [NW:0] s);
    logic [VW:0] r;
    r = {1'b0, s[VW-1:0]};
    if (!s[NW] && (|s[NW-1:VW-1])) begin
      r = {1'b1, 1'b0, {(VW-1){1'b1}}};
    end else if (s[NW] && !(&s[NW-1:VW-1])) begin
      r = {1'b1, 1'b1, {(VW-1){1'b0}}};
    end
    sat = r;
  endfunction

  function automatic lane_t div_init(input logic [NW-1:0] n, input logic [NW-1:0] d);
    lane_t            l;
    logic [NW-1:0]    mn;
    logic [NW+VW-1:0] a;
    logic [NW+VW-1:0] b;
    mn = n[NW-1] ? (~n + NW'(1)) : n;
    a = {{(VW-FB){1'b0}}, mn, {FB{1'b0}}};
    b = {d, {VW{1'b0}}};
    l.big = (a >= b);
    l.neg = n[NW-1];
    l.rem = mn >> (VW - FB);
    l.lq = {mn[VW-FB-1:0], {FB{1'b0}}};
    div_init = l;
  endfunction

  function automatic lane_t div_step(input lane_t l, input logic [NW-1:0] d);
    lane_t       r;
    logic [NW:0] t;
    logic        qb;
    r = l;
    t = {l.rem, l.lq[VW-1]};
    qb = (t >= {1'b0, d});
    if (qb) begin
      t = t - {1'b0, d};
    end
    r.rem = t[NW-1:0];
    r.lq = {l.lq[VW-2:0], qb};
    div_step = r;
  endfunction

  // {ov, quotient} saturated to the value range
  function automatic logic [VW:0] div_fin(input lane_t l);
    logic [VW-1:0] cap;
    logic [VW:0]   r;
    cap = {1'b1, {(VW-1){1'b0}}};
    if (l.neg) begin
      if (l.big || (l.lq > cap)) r = {1'b1, cap};
      else r = {1'b0, ~l.lq + VW'(1)};
    end else begin
      if (l.big || (l.lq >= cap)) r = {1'b1, cap - VW'(1)};
      else r = {1'b0, l.lq};
    end
    div_fin = r;
  endfunction

endpackage

FILE: sv/projective_point_map_jacobian.sv
// ----------------------------------------------------------------------------
// projective_point_map_jacobian
// Maps a point through a 3x3 projective matrix and optionally chains the
// map's Jacobian into the incoming one. Signed Q16.16, saturating.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  input   | in_valid / in_stall, in_*      | item in, one per cycle while in_stall is low
//  result  | out_valid / out_stall, out_*   | one item out per input item
//  config  | cfg_we, cfg_index, cfg_data    | register write, no read-back
//
//  The pipeline takes one item per cycle while in_stall is low.
//  Depth is set by the two restoring dividers, two quotient bits per stage.
//  The pipeline moves in lockstep; a 2-entry output buffer holds results,
//  and in_stall rises only when that buffer is full.
//  Synchronous active-low reset clears valid bits, buffer state, config registers.
module projective_point_map_jacobian import ppmj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CIW-1:0]       cfg_index,
  input  logic [CW-1:0]        cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [VW-1:0] in_point_x,
  input  logic signed [VW-1:0] in_point_y,
  input  logic                 in_point_invalid,
  input  logic                 in_update_jacobian,
  input  logic signed [VW-1:0] in_jac_in_00,
  input  logic signed [VW-1:0] in_jac_in_01,
  input  logic signed [VW-1:0] in_jac_in_10,
  input  logic signed [VW-1:0] in_jac_in_11,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VW-1:0] out_mapped_x,
  output logic signed [VW-1:0] out_mapped_y,
  output logic [1:0]           out_status,
  output logic                 out_overflow,
  output logic signed [VW-1:0] out_jac_out_00,
  output logic signed [VW-1:0] out_jac_out_01,
  output logic signed [VW-1:0] out_jac_out_10,
  output logic signed [VW-1:0] out_jac_out_11
);

  localparam int S_CAP  = 0;
  localparam int S_MUL1 = 1;
  localparam int S_SUM  = 2;
  localparam int S_DIV1 = 3;
  localparam int S_Q    = S_DIV1 + DS;
  localparam int S_MUL2 = S_Q + 1;
  localparam int S_NUM  = S_Q + 2;
  localparam int S_DIV2 = S_Q + 3;
  localparam int S_K    = S_DIV2 + DS;
  localparam int S_MUL3 = S_K + 1;
  localparam int NS     = S_MUL3 + 1;

  logic [CW-1:0] c0_r, c1_r, c2_r, c3_r;
  logic [VW-1:0] c4_r;
  logic [VW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

  item_t      stg_r   [NS];
  item_t      stg_nxt [NS];
  logic [NS-1:0] vld_r;
  logic       en;

  out_t       res;
  out_t       buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_M00_M01: c0_r <= cfg_data;
        CFG_M02_M10: c1_r <= cfg_data;
        CFG_M11_M12: c2_r <= cfg_data;
        CFG_M20_M21: c3_r <= cfg_data;
        CFG_M22:     c4_r <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  assign m00 = c0_r[VW-1:0];
  assign m01 = c0_r[2*VW-1:VW];
  assign m02 = c1_r[VW-1:0];
  assign m10 = c1_r[2*VW-1:VW];
  assign m11 = c2_r[VW-1:0];
  assign m12 = c2_r[2*VW-1:VW];
  assign m20 = c3_r[VW-1:0];
  assign m21 = c3_r[2*VW-1:VW];
  assign m22 = c4_r;

  // Whole pipeline advances unless the output buffer is full.
  assign en = (cnt_r != 2'd2);
  assign in_stall = !en;

  genvar s;
  generate
    for (s = 0; s < NS; s++) begin : g_stg
      if (s == S_CAP) begin : g_cap
        always_comb begin
          stg_nxt[s] = '0;
          stg_nxt[s].x = in_point_x;
          stg_nxt[s].y = in_point_y;
          stg_nxt[s].inv = in_point_invalid;
          stg_nxt[s].upd = in_update_jacobian;
          stg_nxt[s].j00 = in_jac_in_00;
          stg_nxt[s].j01 = in_jac_in_01;
          stg_nxt[s].j10 = in_jac_in_10;
          stg_nxt[s].j11 = in_jac_in_11;
        end
      end else if (s == S_MUL1) begin : g_mul1
        always_comb begin
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].p[0] = smul(stg_r[s-1].x, m10);
          stg_nxt[s].p[1] = smul(stg_r[s-1].y, m20);
          stg_nxt[s].p[2] = smul(stg_r[s-1].x, m11);
          stg_nxt[s].p[3] = smul(stg_r[s-1].y, m21);
          stg_nxt[s].p[4] = smul(stg_r[s-1].x, m12);
          stg_nxt[s].p[5] = smul(stg_r[s-1].y, m22);
        end
      end else if (s == S_SUM) begin : g_sum
        logic [NW-1:0] w, u, v;
        always_comb begin
          w = sxn(m00) + pfl(stg_r[s-1].p[0]) + pfl(stg_r[s-1].p[1]);
          u = sxn(m01) + pfl(stg_r[s-1].p[2]) + pfl(stg_r[s-1].p[3]);
          v = sxn(m02) + pfl(stg_r[s-1].p[4]) + pfl(stg_r[s-1].p[5]);
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].w = w;
          stg_nxt[s].u = u;
          stg_nxt[s].v = v;
          stg_nxt[s].ln[0] = div_init(u, w);
          stg_nxt[s].ln[1] = div_init(v, w);
        end
      end else if (s == S_Q) begin : g_q
        logic [VW:0] fx, fy;
        always_comb begin
          fx = div_fin(stg_r[s-1].ln[0]);
          fy = div_fin(stg_r[s-1].ln[1]);
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].qx = fx[VW-1:0];
          stg_nxt[s].qy = fy[VW-1:0];
          stg_nxt[s].ovq = fx[VW] | fy[VW];
        end
      end else if (s == S_MUL2) begin : g_mul2
        always_comb begin
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].p[0] = smul(stg_r[s-1].qx, m10);
          stg_nxt[s].p[1] = smul(stg_r[s-1].qy, m10);
          stg_nxt[s].p[2] = smul(stg_r[s-1].qx, m20);
          stg_nxt[s].p[3] = smul(stg_r[s-1].qy, m20);
        end
      end else if (s == S_NUM) begin : g_num
        logic [NW-1:0] d;
        always_comb begin
          d = stg_r[s-1].w;
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].ln[0] = div_init(sxn(m11) - pfl(stg_r[s-1].p[0]), d);
          stg_nxt[s].ln[1] = div_init(sxn(m12) - pfl(stg_r[s-1].p[1]), d);
          stg_nxt[s].ln[2] = div_init(sxn(m21) - pfl(stg_r[s-1].p[2]), d);
          stg_nxt[s].ln[3] = div_init(sxn(m22) - pfl(stg_r[s-1].p[3]), d);
        end
      end else if (s == S_K) begin : g_k
        logic [3:0][VW:0] f;
        always_comb begin
          for (int i = 0; i < 4; i++) f[i] = div_fin(stg_r[s-1].ln[i]);
          stg_nxt[s] = stg_r[s-1];
          for (int i = 0; i < 4; i++) stg_nxt[s].k[i] = f[i][VW-1:0];
          stg_nxt[s].ovk = f[0][VW] | f[1][VW] | f[2][VW] | f[3][VW];
        end
      end else if (s == S_MUL3) begin : g_mul3
        always_comb begin
          stg_nxt[s] = stg_r[s-1];
          stg_nxt[s].p[0] = smul(stg_r[s-1].j00, stg_r[s-1].k[0]);
          stg_nxt[s].p[1] = smul(stg_r[s-1].j01, stg_r[s-1].k[2]);
          stg_nxt[s].p[2] = smul(stg_r[s-1].j00, stg_r[s-1].k[1]);
          stg_nxt[s].p[3] = smul(stg_r[s-1].j01, stg_r[s-1].k[3]);
          stg_nxt[s].p[4] = smul(stg_r[s-1].j10, stg_r[s-1].k[0]);
          stg_nxt[s].p[5] = smul(stg_r[s-1].j11, stg_r[s-1].k[2]);
          stg_nxt[s].p[6] = smul(stg_r[s-1].j10, stg_r[s-1].k[1]);
          stg_nxt[s].p[7] = smul(stg_r[s-1].j11, stg_r[s-1].k[3]);
        end
      end else begin : g_div
        // restoring divide steps, all lanes share divisor w
        always_comb begin
          stg_nxt[s] = stg_r[s-1];
          for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < DIV_STEPS; k++) begin
              stg_nxt[s].ln[i] = div_step(stg_nxt[s].ln[i], stg_r[s-1].w);
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stg_r[s] <= stg_nxt[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // final assembly of the result item
  item_t       fi;
  logic [3:0][VW:0] js;
  logic        w_le0;
  always_comb begin
    fi = stg_r[NS-1];
    js[0] = sat(sadd(pfl(fi.p[0]), pfl(fi.p[1])));
    js[1] = sat(sadd(pfl(fi.p[2]), pfl(fi.p[3])));
    js[2] = sat(sadd(pfl(fi.p[4]), pfl(fi.p[5])));
    js[3] = sat(sadd(pfl(fi.p[6]), pfl(fi.p[7])));
    w_le0 = fi.w[NW-1] || (fi.w == '0);
    res.jac = {fi.j11, fi.j10, fi.j01, fi.j00};
    res.ov = 1'b0;
    if (fi.inv) begin
      res.mx = fi.x;
      res.my = fi.y;
      res.status = ST_INVALID;
    end else if (w_le0) begin
      res.mx = '0;
      res.my = '0;
      res.status = ST_INF;
    end else begin
      res.mx = fi.qx;
      res.my = fi.qy;
      res.status = ST_VALID;
      res.ov = fi.ovq;
      if (fi.upd) begin
        for (int i = 0; i < 4; i++) res.jac[i] = js[i][VW-1:0];
        res.ov = fi.ovq | fi.ovk | js[0][VW] | js[1][VW] | js[2][VW] | js[3][VW];
      end
    end
  end

  // 2-entry output buffer
  assign push = en && vld_r[NS-1];
  assign pop = (cnt_r != 2'd0) && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= res;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_mapped_x = buf_r[rd_ptr_r].mx;
  assign out_mapped_y = buf_r[rd_ptr_r].my;
  assign out_status = buf_r[rd_ptr_r].status;
  assign out_overflow = buf_r[rd_ptr_r].ov;
  assign out_jac_out_00 = buf_r[rd_ptr_r].jac[0];
  assign out_jac_out_01 = buf_r[rd_ptr_r].jac[1];
  assign out_jac_out_10 = buf_r[rd_ptr_r].jac[2];
  assign out_jac_out_11 = buf_r[rd_ptr_r].jac[3];

endmodule
